@@ sv/quadrature_index_position_counter_defines.svh @@
// ----------------------------------------------------------------------------
// Quadrature index position counter assertion macros
// Shared concurrent assertion forms for the counter RTL.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_INDEX_POSITION_COUNTER_DEFINES_SVH
`define QUADRATURE_INDEX_POSITION_COUNTER_DEFINES_SVH

// checked at every edge outside reset
`define QIPC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define QIPC_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/qipc_pkg.sv @@
// ----------------------------------------------------------------------------
// qipc_pkg
// Types, register map and helper functions for the quadrature counter.
// ----------------------------------------------------------------------------
`default_nettype none

package qipc_pkg;

   localparam int TICKS_WIDTH = 24;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register index (byte address / 4)
   localparam logic REG_TICKS_PER_TURN = 1'b0;
   localparam logic REG_ARMED          = 1'b1;

   // n/5 for n < 2^24: (n * ceil(2^26/5)) >> 26
   localparam logic [23:0] DIV5_MULT  = 24'd13421773;
   localparam int          DIV5_SHIFT = 26;

   // Gray phase codes {a,b}
   localparam logic [1:0] PHASE_00 = 2'b00;
   localparam logic [1:0] PHASE_01 = 2'b01;
   localparam logic [1:0] PHASE_11 = 2'b11;
   localparam logic [1:0] PHASE_10 = 2'b10;

   typedef struct packed {
      logic [TICKS_WIDTH-1:0] ticks_per_turn;
      logic [TICKS_WIDTH-1:0] wrap_thresh;    // (ticks_per_turn / 5) * 4
      logic                   armed;
      logic                   clear_zero;     // pulse on any register write
   } cfg_type;

   // position of a phase along the up-count Gray sequence
   function automatic logic [1:0] gray_pos(input logic [1:0] phase);
      logic [1:0] pos;
      case (phase)
         PHASE_00: pos = 2'd0;
         PHASE_01: pos = 2'd1;
         PHASE_11: pos = 2'd2;
         PHASE_10: pos = 2'd3;
         default:  pos = 2'd0;
      endcase
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ sv/quadrature_index_position_counter.sv @@
// ----------------------------------------------------------------------------
// quadrature_index_position_counter
// Quadrature decoder with wrap to ticks per turn and index mark qualification.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | flow
//  req_    | in  | chan_a, chan_b, index_level, index_edge   | tvalid/tready
//  rsp_    | out | position, raw_count, zero_found, idx_acc  | tvalid/tready
//  csr_    | in  | ticks_per_turn (0x0), armed (0x4)         | APB, pready=1
//
//  One word in, one word out; a new word is taken every
//  cycle while the result register is empty or being drained.
//  The count, phase and mark state close a registered loop through the
//  step / wrap / mark-distance logic.
//  Synchronous reset clears the phase, count, mark latch and zero flag.
//  A stalled rsp_ side holds the result register and stops req_.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_index_position_counter_defines.svh"

module quadrature_index_position_counter
   import qipc_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // [0] chan_a, [1] chan_b, [2] index_level, [3] index_edge, [7:4] zero
   input  wire logic [7:0]                req_tdata,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // [23:0] position, [55:24] raw_count, [56] zero_found,
   // [57] index_accepted, [63:58] zero
   output logic [63:0]                    rsp_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int CW = COUNT_WIDTH;
   // wide enough for count difference plus ticks per turn
   localparam int WW = ((CW + 1 > TICKS_WIDTH + 1) ? CW + 1 : TICKS_WIDTH + 1) + 1;

   cfg_type cfg;

   qipc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // state
   logic [1:0]           phase_ff, phase_in;
   logic signed [CW-1:0] tick_ff, tick_in;
   logic signed [CW-1:0] mstart_ff, mstart_in;
   logic                 mvalid_ff, mvalid_in;
   logic                 zero_ff, zero_in;
   logic [63:0]          out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;

   logic                 in_a, in_b, in_lvl, in_edge, req_acc;
   logic [1:0]           new_phase, step;
   logic signed [CW-1:0] cnt_step, cnt_f1, cnt_f2;
   logic signed [WW-1:0] t_w, thr_w, cnt_w, diff, mag_d, d1, d2;
   logic                 is_start, is_end, far, unit_dist, accepted;
   logic signed [31:0]   raw32;
   logic [TICKS_WIDTH-1:0] pos;

   assign in_a    = req_tdata[0];
   assign in_b    = req_tdata[1];
   assign in_lvl  = req_tdata[2];
   assign in_edge = req_tdata[3];

   assign req_tready = ~out_vld_ff | rsp_tready;
   assign req_acc    = req_tvalid & req_tready;

   assign t_w   = WW'({1'b0, cfg.ticks_per_turn});
   assign thr_w = WW'({1'b0, cfg.wrap_thresh});

   always_comb begin
      new_phase = {in_a, in_b};
      step      = gray_pos(new_phase) - gray_pos(phase_ff);
      phase_in  = phase_ff;
      cnt_step  = tick_ff;
      if (step == 2'd1) begin
         cnt_step = tick_ff + CW'(1);
         phase_in = new_phase;
      end else if (step == 2'd3) begin
         cnt_step = tick_ff - CW'(1);
         phase_in = new_phase;
      end

      // fold into 0..ticks_per_turn (strict greater-than on the top end)
      cnt_f1 = cnt_step[CW-1] ? cnt_step + t_w[CW-1:0] : cnt_step;
      cnt_w  = WW'(cnt_f1);
      cnt_f2 = (cnt_w > t_w) ? cnt_f1 - t_w[CW-1:0] : cnt_f1;

      is_start = in_edge & in_lvl & ~in_a & ~in_b;
      is_end   = in_edge & ~is_start;

      // mark distance, corrected across the wrap point
      diff  = WW'(mstart_ff) - WW'(cnt_f2);
      mag_d = diff[WW-1] ? -diff : diff;
      far   = mag_d > thr_w;
      d1    = (far && diff[WW-1]) ? diff + t_w : diff;
      d2    = (far && (d1 > 0)) ? t_w - d1 : d1;
      unit_dist = (d2 == WW'(1)) || (d2 == -WW'(1));

      accepted = is_end & mvalid_ff & (in_a ^ in_b) & unit_dist;

      tick_in   = accepted ? '0 : cnt_f2;
      mvalid_in = is_start ? 1'b1 : (is_end ? 1'b0 : mvalid_ff);
      mstart_in = is_start ? cnt_f2 : (is_end ? '1 : mstart_ff);

      zero_in = zero_ff;
      if (accepted && cfg.armed) begin
         zero_in = 1'b1;
      end

      raw32  = 32'(tick_in);
      pos    = zero_in ? raw32[TICKS_WIDTH-1:0] : '0;
      out_in = {6'd0, accepted, zero_in, raw32, pos};
   end

   assign out_vld_in = req_acc | (out_vld_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_00;
         tick_ff    <= '0;
         mstart_ff  <= '1;
         mvalid_ff  <= 1'b0;
         zero_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
         if (cfg.clear_zero) begin
            zero_ff <= 1'b0;
         end else if (req_acc) begin
            zero_ff <= zero_in;
         end
         if (req_acc) begin
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
            mstart_ff <= mstart_in;
            mvalid_ff <= mvalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tdata  = out_ff;
   assign rsp_tvalid = out_vld_ff;

   `QIPC_ASSERT_RST(a_word_gives_result, clock, reset,
      req_acc |=> rsp_tvalid, "accepted word produced no result")
   `QIPC_ASSERT_RST(a_pos_zero_until_found, clock, reset,
      (rsp_tvalid && !rsp_tdata[56]) |-> (rsp_tdata[23:0] == 24'd0),
      "position nonzero before zero mark found")
   `QIPC_ASSERT_RST(a_index_zeroes_count, clock, reset,
      (rsp_tvalid && rsp_tdata[57]) |-> (rsp_tdata[55:24] == 32'd0),
      "accepted index mark did not zero the count")
   `QIPC_ASSERT_RST(a_zero_rise_cause, clock, reset,
      $rose(zero_ff) |-> $past(req_acc && accepted && cfg.armed),
      "zero flag set without an armed index mark")
   `QIPC_ASSERT_CLK(a_reset_clears, clock,
      $past(reset) |-> (!rsp_tvalid && !zero_ff && !mvalid_ff),
      "control state not cleared by reset")

endmodule

`default_nettype wire

@@ sv/qipc_csr.sv @@
// ----------------------------------------------------------------------------
// qipc_csr
// APB register file: ticks per turn, armed flag and the wrap threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module qipc_csr
   import qipc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output cfg_type                        cfg
);

   logic [TICKS_WIDTH-1:0] ticks_ff, ticks_in;
   logic [TICKS_WIDTH-1:0] thresh_ff, thresh_in;
   logic                   armed_ff, armed_in;
   logic                   clear_in;
   logic                   wr_en;
   logic                   reg_idx;
   logic [47:0]            div_prod;
   logic [TICKS_WIDTH-1:0] div_quot;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[2];

   // threshold worked out once at write time, off the count path
   assign div_prod = {24'd0, pwdata[TICKS_WIDTH-1:0]} * {24'd0, DIV5_MULT};
   assign div_quot = div_prod[DIV5_SHIFT +: TICKS_WIDTH];

   always_comb begin
      ticks_in  = ticks_ff;
      thresh_in = thresh_ff;
      armed_in  = armed_ff;
      clear_in  = 1'b0;
      if (wr_en) begin
         clear_in = 1'b1;
         unique case (reg_idx)
            REG_TICKS_PER_TURN: begin
               ticks_in  = pwdata[TICKS_WIDTH-1:0];
               thresh_in = {div_quot[TICKS_WIDTH-3:0], 2'b00};
            end
            REG_ARMED: begin
               armed_in = pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff  <= '0;
         thresh_ff <= '0;
         armed_ff  <= 1'b0;
      end else begin
         ticks_ff  <= ticks_in;
         thresh_ff <= thresh_in;
         armed_ff  <= armed_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TICKS_PER_TURN: prdata = {{(CSR_DATA_WIDTH-TICKS_WIDTH){1'b0}}, ticks_ff};
         REG_ARMED:          prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, armed_ff};
         default:            prdata = '0;
      endcase
   end

   // clear goes out in the write cycle itself so the next word sees it
   assign cfg = '{ticks_per_turn: ticks_ff,
                  wrap_thresh:    thresh_ff,
                  armed:          armed_ff,
                  clear_zero:     clear_in};

endmodule

`default_nettype wire
